FILE: rtl/pste_pkg.sv
// package for the pwm shadow transaction engine
// holds the command, status and state codes and the request and response item types
// no dependencies
package pste_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_LEVEL = 2'd2,
    CMD_PULSE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_BUSY      = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_ONE,
    ACT_ALL,
    ACT_FLUSH
  } action_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_ALL,
    FSM_FLUSH_RD,
    FSM_FLUSH
  } fsm_state_e;

  typedef enum logic {
    REG_DEVICE_READY = 1'b0,
    REG_ALL_BASE     = 1'b1
  } reg_index_e;

  localparam logic [7:0] ALL_BASE_RESET = 8'd250;

  typedef struct packed {
    cmd_e        command;
    logic [4:0]  channel;
    logic        all_channels;
    logic        level_on;
    logic [15:0] phase_delay;
    logic [15:0] active_len;
  } request_t;

  typedef struct packed {
    status_e    status;
    logic       has_byte;
    logic [7:0] reg_address;
    logic [7:0] data_byte;
    logic       last;
  } response_t;

endpackage

FILE: rtl/pwm_shadow_transaction_engine_top.sv
// pwm shadow transaction engine, top level
// shadow row memory, transaction decode, flush sequencer and config registers
// depends on pste_pkg
//
// usage: an item on request is taken at a rising edge with start high and busy low.
// results come out on response, one per cycle, each marked by response_valid for a
// single cycle; they cannot be held off. every item gives at least one result and
// the last result of an item carries last.
// items that write no byte (start, nested end, an outermost end with no dirty channel,
// errors, nested channel updates) answer in the cycle after acceptance and leave busy
// low, so one may follow every cycle. an all-channel update gives 4 bytes from state
// FSM_ALL, busy while it gives them. an outermost end flushes the dirty channel range
// and a top-level channel update flushes only its own channel: first a row read of the
// shadow memory in FSM_FLUSH_RD, then 4 bytes per channel, one a cycle, the next row
// read overlapping the last byte. busy stays high until the last byte is on response.
// the shadow rows are tracked by one valid bit per channel, so reset takes effect at
// once: all channels read as on tick PERIOD_TICKS and off tick 0, nothing nested,
// device_ready 0 and all_channel_base 250. config writes go through the apb port;
// the user must make them only while the block is idle, the block does not enforce it.
module pwm_shadow_transaction_engine_top #(
  parameter int NUM_CHANNELS      = 16,
  parameter int PERIOD_TICKS      = 4096,
  parameter int CHANNEL_BASE_ADDR = 6,
  parameter int MAX_NEST          = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pste_pkg::request_t  request,
  output logic                response_valid,
  output pste_pkg::response_t response,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pste_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DF_W   = $clog2(NUM_CHANNELS + 1);
  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int TICK_W = $clog2(PERIOD_TICKS + 1);
  localparam int SUM_W  = TICK_W + 1;
  localparam logic [31:0] RESET_ROW = {8'h00, 8'h00, 8'(PERIOD_TICKS >> 8),
                                       8'(PERIOD_TICKS)};

  logic              device_ready;
  logic [7:0]        all_base;
  logic [NEST_W-1:0] nest_depth;
  logic [DF_W-1:0]   dirty_first;
  logic [CH_W-1:0]   dirty_last;

  fsm_state_e        state;
  fsm_state_e        state_next;
  logic [1:0]        byte_idx;
  logic [CH_W-1:0]   flush_ch;
  logic [CH_W-1:0]   flush_end;
  logic [31:0]       row_hold;

  logic [31:0]       shadow_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] row_valid;
  logic [31:0]       rd_raw;
  logic              rd_hit;
  logic [31:0]       rd_row;
  logic              rd_en;
  logic [CH_W-1:0]   rd_addr;

  logic              accept;
  logic              cfg_write;
  logic              depth_zero;
  logic              depth_one;
  logic              range_ok;
  logic              ch_bad;
  logic              pulse_bad;
  status_e           start_st;
  logic [CH_W-1:0]   ch_idx;
  logic [TICK_W-1:0] on_tick;
  logic [TICK_W-1:0] off_count;
  logic [SUM_W-1:0]  tick_sum;
  logic [15:0]       on_ext;
  logic [15:0]       off_ext;
  logic [31:0]       row_new;
  logic [DF_W-1:0]   base_first;
  logic [CH_W-1:0]   base_last;
  logic [DF_W-1:0]   new_first;
  logic [CH_W-1:0]   new_last;

  action_e           act;
  status_e           dec_status;
  logic [NEST_W-1:0] depth_next;
  logic [DF_W-1:0]   first_next;
  logic [CH_W-1:0]   last_next;
  logic              wr_en;
  logic [CH_W-1:0]   fl_first;
  logic [CH_W-1:0]   fl_last;

  logic              flush_done;
  logic              resp_valid_next;
  response_t         resp_next;

  assign busy      = (state != FSM_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_ready <= 1'b0;
      all_base     <= ALL_BASE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_e'(paddr[2]))
        REG_DEVICE_READY: device_ready <= pwdata[0];
        REG_ALL_BASE:     all_base     <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_e'(paddr[2]))
      REG_DEVICE_READY: prdata = {31'd0, device_ready};
      REG_ALL_BASE:     prdata = {24'd0, all_base};
    endcase
  end

  // tick computation
  assign pulse_bad = (request.command == CMD_PULSE) &&
                     (request.phase_delay >= 16'(PERIOD_TICKS));
  assign tick_sum  = {1'b0, request.phase_delay[TICK_W-1:0]} +
                     {1'b0, request.active_len[TICK_W-1:0]};

  always_comb begin
    if (request.command == CMD_LEVEL) begin
      if (request.level_on) begin
        on_tick   = '0;
        off_count = TICK_W'(PERIOD_TICKS);
      end else begin
        on_tick   = TICK_W'(PERIOD_TICKS);
        off_count = '0;
      end
    end else if (request.active_len >= 16'(PERIOD_TICKS)) begin
      on_tick   = '0;
      off_count = TICK_W'(PERIOD_TICKS);
    end else if (request.active_len == 16'd0) begin
      on_tick   = TICK_W'(PERIOD_TICKS);
      off_count = '0;
    end else begin
      on_tick = request.phase_delay[TICK_W-1:0];
      if (tick_sum >= SUM_W'(PERIOD_TICKS)) begin
        off_count = TICK_W'(tick_sum - SUM_W'(PERIOD_TICKS));
      end else begin
        off_count = TICK_W'(tick_sum - SUM_W'(1));
      end
    end
  end

  assign on_ext  = 16'(on_tick);
  assign off_ext = 16'(off_count);
  assign row_new = {off_ext[15:8], off_ext[7:0], on_ext[15:8], on_ext[7:0]};

  // transaction decode
  assign depth_zero = (nest_depth == '0);
  assign depth_one  = (nest_depth == NEST_W'(1));
  assign ch_bad     = (request.channel >= 5'(NUM_CHANNELS));
  assign ch_idx     = request.channel[CH_W-1:0];
  assign range_ok   = (dirty_first < DF_W'(NUM_CHANNELS)) &&
                      (DF_W'(dirty_last) >= dirty_first) &&
                      (DF_W'(dirty_last) < DF_W'(NUM_CHANNELS));
  assign base_first = depth_zero ? DF_W'(NUM_CHANNELS) : dirty_first;
  assign base_last  = depth_zero ? '0 : dirty_last;
  assign new_first  = (DF_W'(ch_idx) < base_first) ? DF_W'(ch_idx) : base_first;
  assign new_last   = (ch_idx > base_last) ? ch_idx : base_last;

  always_comb begin
    if (nest_depth >= NEST_W'(MAX_NEST)) begin
      start_st = ST_INVALID;
    end else if (depth_zero && !device_ready) begin
      start_st = ST_NOT_READY;
    end else begin
      start_st = ST_OK;
    end
  end

  always_comb begin
    act        = ACT_ONE;
    dec_status = ST_OK;
    depth_next = nest_depth;
    first_next = dirty_first;
    last_next  = dirty_last;
    wr_en      = 1'b0;
    fl_first   = dirty_first[CH_W-1:0];
    fl_last    = dirty_last;
    unique case (request.command)
      CMD_START: begin
        dec_status = start_st;
        if (start_st == ST_OK) begin
          depth_next = nest_depth + NEST_W'(1);
          if (depth_zero) begin
            first_next = DF_W'(NUM_CHANNELS);
            last_next  = '0;
          end
        end
      end
      CMD_END: begin
        if (depth_zero) begin
          dec_status = ST_INVALID;
        end else begin
          depth_next = nest_depth - NEST_W'(1);
          if (depth_one && range_ok) begin
            act = ACT_FLUSH;
          end
        end
      end
      CMD_LEVEL, CMD_PULSE: begin
        if (pulse_bad) begin
          dec_status = ST_INVALID;
        end else if (start_st != ST_OK) begin
          dec_status = start_st;
        end else begin
          if (depth_zero) begin
            first_next = DF_W'(NUM_CHANNELS);
            last_next  = '0;
          end
          if (request.all_channels) begin
            if (!depth_zero) begin
              dec_status = ST_BUSY;
            end else begin
              act = ACT_ALL;
            end
          end else if (ch_bad) begin
            dec_status = ST_INVALID;
          end else begin
            wr_en      = 1'b1;
            first_next = new_first;
            last_next  = new_last;
            if (depth_zero) begin
              act      = ACT_FLUSH;
              fl_first = ch_idx;
              fl_last  = ch_idx;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_depth  <= '0;
      dirty_first <= DF_W'(NUM_CHANNELS);
      dirty_last  <= '0;
    end else if (accept) begin
      nest_depth  <= depth_next;
      dirty_first <= first_next;
      dirty_last  <= last_next;
    end
  end

  // shadow row memory
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      shadow_mem[ch_idx] <= row_new;
    end
    if (rd_en) begin
      rd_raw <= shadow_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (accept && wr_en) begin
      row_valid[ch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit <= row_valid[rd_addr];
    end
  end

  assign rd_row     = rd_hit ? rd_raw : RESET_ROW;
  assign flush_done = (flush_ch == flush_end);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept && act == ACT_ALL) begin
          state_next = FSM_ALL;
        end else if (accept && act == ACT_FLUSH) begin
          state_next = FSM_FLUSH_RD;
        end
      end
      FSM_ALL: begin
        if (byte_idx == 2'd3) begin
          state_next = FSM_IDLE;
        end
      end
      FSM_FLUSH_RD: state_next = FSM_FLUSH;
      FSM_FLUSH: begin
        if (byte_idx == 2'd3 && flush_done) begin
          state_next = FSM_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    resp_valid_next = 1'b0;
    resp_next       = '{status: ST_OK, has_byte: 1'b0, reg_address: 8'd0,
                        data_byte: 8'd0, last: 1'b1};
    rd_en           = 1'b0;
    rd_addr         = flush_ch;
    unique case (state)
      FSM_IDLE: begin
        resp_valid_next  = accept && (act == ACT_ONE);
        resp_next.status = dec_status;
      end
      FSM_ALL: begin
        resp_valid_next       = 1'b1;
        resp_next.has_byte    = 1'b1;
        resp_next.reg_address = all_base + 8'(byte_idx);
        resp_next.data_byte   = row_hold[{byte_idx, 3'b000} +: 8];
        resp_next.last        = (byte_idx == 2'd3);
      end
      FSM_FLUSH_RD: begin
        rd_en = 1'b1;
      end
      FSM_FLUSH: begin
        resp_valid_next       = 1'b1;
        resp_next.has_byte    = 1'b1;
        resp_next.reg_address = 8'(CHANNEL_BASE_ADDR) + 8'({flush_ch, byte_idx});
        resp_next.data_byte   = rd_row[{byte_idx, 3'b000} +: 8];
        resp_next.last        = (byte_idx == 2'd3) && flush_done;
        rd_en                 = (byte_idx == 2'd3) && !flush_done;
        rd_addr               = flush_ch + CH_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      byte_idx <= '0;
    end else begin
      state <= state_next;
      if (state == FSM_ALL || state == FSM_FLUSH) begin
        byte_idx <= byte_idx + 2'd1;
      end else begin
        byte_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flush_ch  <= fl_first;
      flush_end <= fl_last;
      row_hold  <= row_new;
    end else if (state == FSM_FLUSH && byte_idx == 2'd3 && !flush_done) begin
      flush_ch <= flush_ch + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_valid <= 1'b0;
    end else begin
      response_valid <= resp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    response <= resp_next;
  end

  // checks
  a_nobyte_alone: assert property (@(posedge clk) disable iff (rst)
    response_valid && !response.has_byte |-> response.last)
    else $error("result without a byte is not the only result of its item");

  a_err_nobyte: assert property (@(posedge clk) disable iff (rst)
    response_valid && response.status != ST_OK |-> !response.has_byte)
    else $error("failed item produced a register byte");

  a_flush_overlap: assert property (@(posedge clk) disable iff (rst)
    state == FSM_FLUSH && byte_idx == 2'd3 && !flush_done
      |=> state == FSM_FLUSH && byte_idx == 2'd0)
    else $error("flush lost the overlapped row read");

  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_FLUSH_RD || state == FSM_FLUSH) |-> flush_ch <= flush_end)
    else $error("flush channel ran past the dirty range");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without an accepted item");

endmodule
